/* sv/psom_pkg.sv */
package psom_pkg;

    localparam int VOICES         = 13;
    localparam int PHASE_BITS     = 24;
    localparam int SINE_ADDR_BITS = 10;

    localparam int KEY_W    = 13;
    localparam int AMP_W    = 12;
    localparam int SAMPLE_W = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(3000);

    // quarter wave table holds the end point too, so it has one entry more
    localparam int QUARTER = 1 << (SINE_ADDR_BITS - 2);
    localparam int QIDX_W  = SINE_ADDR_BITS - 1;
    localparam int QDEPTH  = QUARTER + 1;
    localparam int SINE_W  = 15;
    localparam int PROD_W  = SINE_W + 1 + AMP_W + 1;
    localparam int TERM_W  = PROD_W - 15;
    localparam int CNT_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MAG_W   = $clog2(VOICES * 4095 + 1);
    localparam int SUM_W   = (MAG_W > 16) ? MAG_W + 1 : 17;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [63:0] RATE_CENTI_HZ = 64'd4410000;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] ONE_Q30       = 64'd1 << 30;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef phase_t tuning_tab_t [VOICES];
    typedef logic [SINE_W-1:0] qrom_tab_t [QDEPTH];
    typedef logic [31:0] note_tab_t [13];

    localparam note_tab_t NOTE_CENTI_HZ = '{
        32'd26163, 32'd27718, 32'd29366, 32'd31113, 32'd32963, 32'd34923, 32'd36999,
        32'd39200, 32'd41530, 32'd44000, 32'd46616, 32'd49388, 32'd52325
    };

    typedef struct packed {
        phase_t phase;
        logic   held;
    } cell_data_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic active;
        logic held;
        logic first;
        logic last;
    } step_t;

    function automatic logic [63:0] voice_centi_hz(input int k);
        logic [63:0] f;
        if (k < 13)
            f = 64'(NOTE_CENTI_HZ[k]);
        else
            f = 64'(NOTE_CENTI_HZ[k % 12]) << (k / 12);
        return f;
    endfunction

    function automatic tuning_tab_t build_tuning();
        tuning_tab_t tab;
        logic [63:0] w;
        for (int k = 0; k < VOICES; k++)
        begin
            w = ((voice_centi_hz(k) << PHASE_BITS) + (RATE_CENTI_HZ >> 1)) / RATE_CENTI_HZ;
            tab[k] = w[PHASE_BITS-1:0];
        end
        return tab;
    endfunction

    // taylor series to degree 9 at q30, rounded to q15
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (m * HALF_PI_Q30) >> (SINE_ADDR_BITS - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (s + (64'd1 << 14)) >> 15;
        if (r > 64'd32767)
            r = 64'd32767;
        return r[SINE_W-1:0];
    endfunction

    function automatic qrom_tab_t build_qrom();
        qrom_tab_t tab;
        for (int m = 0; m < QDEPTH; m++)
            tab[m] = quarter_sine(64'(m));
        return tab;
    endfunction

    localparam tuning_tab_t TUNING = build_tuning();
    localparam qrom_tab_t   QROM   = build_qrom();

endpackage

/* sv/psom_cell.sv */
module psom_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psom_pkg::cell_ctrl_t   ctrl,
    input  logic                   held_load,
    input  psom_pkg::cell_data_t   din,
    output psom_pkg::cell_data_t   dout
);
    import psom_pkg::*;

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = din;
        end
        else if (ctrl.load)
        begin
            data_next.held = held_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

/* sv/psom_voice_unit.sv */
module psom_voice_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  psom_pkg::step_t                     step,
    input  psom_pkg::phase_t                    phase_in,
    input  logic [psom_pkg::CNT_W-1:0]          voice,
    input  logic [psom_pkg::AMP_W-1:0]          amplitude,
    output psom_pkg::phase_t                    phase_new,
    output logic                                done,
    output logic signed [psom_pkg::SUM_W-1:0]   acc
);
    import psom_pkg::*;

    logic [SINE_ADDR_BITS-1:0] addr;
    logic [QIDX_W-1:0]         r_ext;
    logic [QIDX_W-1:0]         m_idx;

    step_t                     tag1_reg;
    step_t                     tag2_reg;
    step_t                     tag3_reg;
    logic [QIDX_W-1:0]         m1_reg;
    logic                      neg1_reg;
    logic [SINE_W-1:0]         rom2_reg;
    logic                      neg2_reg;
    logic signed [SINE_W:0]    sine_s;
    logic signed [PROD_W-1:0]  prod3_reg;
    logic signed [PROD_W-1:0]  adj;
    logic signed [TERM_W-1:0]  term;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   acc_next;
    logic                      done_reg;

    // head cell goes through the accumulator and back to the tail
    assign phase_new = step.held ? phase_in + TUNING[voice] : phase_in;

    // fold the full turn onto the quarter wave
    assign addr  = phase_new[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign r_ext = {1'b0, addr[SINE_ADDR_BITS-3:0]};
    assign m_idx = addr[SINE_ADDR_BITS-2] ? QIDX_W'(QUARTER) - r_ext : r_ext;

    always_ff @(posedge clk)
    begin
        m1_reg    <= m_idx;
        neg1_reg  <= addr[SINE_ADDR_BITS-1];
        rom2_reg  <= QROM[m1_reg];
        neg2_reg  <= neg1_reg;
        prod3_reg <= sine_s * $signed({1'b0, amplitude});
    end

    assign sine_s = neg2_reg ? -$signed({1'b0, rom2_reg}) : $signed({1'b0, rom2_reg});

    // divide by 32768 with truncation toward zero
    assign adj  = prod3_reg + (prod3_reg[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    assign term = TERM_W'(adj >>> 15);

    always_comb
    begin
        acc_next = tag3_reg.first ? '0 : acc_reg;
        if (tag3_reg.held)
        begin
            acc_next = acc_next + SUM_W'(term);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag1_reg <= step;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            done_reg <= tag3_reg.active & tag3_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag3_reg.active)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

/* sv/polyphonic_sine_oscillator_mixer_top.sv */
// polyphonic sine oscillator mixer
// in channel: key_mask with in_valid / in_ready, one item per audio sample tick;
// bit k set advances voice k by its tuning word and adds its sine to the mix
// out channel: sample (signed, saturated) and clipped with out_valid / out_ready
// apb port: amplitude at byte address 0, written at psel & penable & pwrite;
// only paddr[2] decodes: if set, writes drop and reads give 0, else the register
// the voice phases sit in a ring of cells; while an item runs the ring rotates
// once, one voice per cycle, through a shared unit (phase add, quarter wave rom,
// amplitude multiply, accumulate) that is four stages deep
// a new item is taken only after the ring rotation and the unit's pipeline drain
// in_ready is high only while no item is in the ring; a finished result goes to
// the output register and the next item can be taken while it waits
// if the receiver stalls with the output register full, the finished sum is
// held and in_ready stays low until the output register frees up
// reset: all phases zero, amplitude 3000, no result pending
module polyphonic_sine_oscillator_mixer_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [psom_pkg::KEY_W-1:0]              key_mask,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [psom_pkg::SAMPLE_W-1:0]    sample,
    output logic                                    clipped,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [psom_pkg::PADDR_W-1:0]            paddr,
    input  logic [psom_pkg::PDATA_W-1:0]            pwdata,
    output logic [psom_pkg::PDATA_W-1:0]            prdata,
    output logic                                    pready
);
    import psom_pkg::*;

    localparam logic REG_AMPLITUDE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(SAMPLE_MAX);
    localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(SAMPLE_MIN);

    state_t                       state_reg;
    state_t                       state_next;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [AMP_W-1:0]             amp_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic                         clipped_reg;

    logic                         accept;
    logic                         cfg_write;
    logic                         cnt_last;
    logic                         out_free;
    logic                         out_load;
    logic signed [SAMPLE_W-1:0]   sat_sample;
    logic                         sat_clip;

    cell_ctrl_t                   cell_ctrl;
    cell_data_t                   chain [VOICES];
    step_t                        step;
    phase_t                       u_phase;
    logic                         u_done;
    logic signed [SUM_W-1:0]      u_acc;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_AMPLITUDE);
    assign prdata    = (paddr[2] == REG_AMPLITUDE) ? PDATA_W'(amp_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= AMP_RESET;
        end
        else if (cfg_write)
        begin
            amp_reg <= pwdata[AMP_W-1:0];
        end
    end

    // voice ring
    assign accept          = in_valid & in_ready;
    assign cell_ctrl.load  = accept;
    assign cell_ctrl.shift = (state_reg == ST_RUN);

    for (genvar k = 0; k < VOICES; k++)
    begin : g_cell
        cell_data_t din;
        logic       held_bit;

        if (k == VOICES - 1)
        begin : g_tail
            assign din = '{phase: u_phase, held: 1'b0};
        end
        else
        begin : g_mid
            assign din = chain[k+1];
        end

        if (k < KEY_W)
        begin : g_key
            assign held_bit = key_mask[k];
        end
        else
        begin : g_nokey
            assign held_bit = 1'b0;
        end

        psom_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .held_load (held_bit),
            .din       (din),
            .dout      (chain[k])
        );
    end

    assign cnt_last    = (cnt_reg == CNT_W'(VOICES - 1));
    assign step.active = (state_reg == ST_RUN);
    assign step.held   = (state_reg == ST_RUN) & chain[0].held;
    assign step.first  = (cnt_reg == '0);
    assign step.last   = cnt_last;

    psom_voice_unit u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .phase_in  (chain[0].phase),
        .voice     (cnt_reg),
        .amplitude (amp_reg),
        .phase_new (u_phase),
        .done      (u_done),
        .acc       (u_acc)
    );

    // saturating output
    always_comb
    begin
        sat_clip   = 1'b0;
        sat_sample = u_acc[SAMPLE_W-1:0];
        if (u_acc > SUM_HI)
        begin
            sat_clip   = 1'b1;
            sat_sample = SAMPLE_MAX;
        end
        else if (u_acc < SUM_LO)
        begin
            sat_clip   = 1'b1;
            sat_sample = SAMPLE_MIN;
        end
    end

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (cnt_last)
                begin
                    state_next = ST_WAIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (u_done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_reg  <= sat_sample;
            clipped_reg <= sat_clip;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign clipped   = clipped_reg;

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |-> ((sample == SAMPLE_MAX) || (sample == SAMPLE_MIN)))
        else $error("clipped result not at a rail");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= CNT_W'(VOICES - 1)))
        else $error("voice counter out of range");

    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_RUN))
        else $error("accepted item did not start the ring");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> (state_reg == ST_WAIT))
        else $error("sum finished outside the wait state");

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cnt_last) |=> (state_reg == ST_WAIT && cnt_reg == '0))
        else $error("ring rotation did not end cleanly");

endmodule

/* sim/sine_mix_checker.sv */
module sine_mix_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [psom_pkg::KEY_W-1:0]           key_mask,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [psom_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 clipped,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [psom_pkg::PADDR_W-1:0]         paddr,
    input  logic [psom_pkg::PDATA_W-1:0]         pwdata,
    input  logic [psom_pkg::PDATA_W-1:0]         prdata,
    input  logic                                 pready,
    output int                                   mismatches,
    output int                                   outstanding,
    output int                                   checked,
    output int                                   clips
);
    timeunit 1ns;
    timeprecision 1ps;

    import psom_pkg::*;

    localparam logic [PADDR_W-1:0] AMP_ADDR = PADDR_W'(0);
    localparam int TAB_N = 1 << SINE_ADDR_BITS;
    localparam int QTR   = TAB_N / 4;
    localparam logic [63:0] SAMPLE_RATE_CHZ = 64'd4410000;
    localparam logic [63:0] PI_HALF_Q30     = 64'd1686629713;
    localparam logic [63:0] UNITY_Q30       = 64'd1 << 30;

    typedef struct {
        logic signed [SAMPLE_W-1:0] level;
        logic                       sat;
    } mix_result_t;

    // note frequencies c4..c5 in hundredths of a hertz
    localparam int unsigned PITCH_CHZ [13] = '{
        26163, 27718, 29366, 31113, 32963, 34923, 36999,
        39200, 41530, 44000, 46616, 49388, 52325
    };

    int                    sine_tab [TAB_N];
    logic [PHASE_BITS-1:0] step_word [VOICES];
    logic [PHASE_BITS-1:0] voice_phase [VOICES];
    logic [AMP_W-1:0]      amp_setting;
    mix_result_t           pending_mix [$];

    // sine over a quarter turn, q15, horner form of the degree 9 series at q30
    function automatic int quarter_wave_q15(input int unsigned step);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] poly;
        logic [63:0] prod;
        logic [63:0] q15;
        ang    = (64'(step) * PI_HALF_Q30) >> (SINE_ADDR_BITS - 2);
        ang_sq = (ang * ang) >> 30;
        poly   = UNITY_Q30 - ang_sq / 64'd72;
        poly   = UNITY_Q30 - ((ang_sq * poly) >> 30) / 64'd42;
        poly   = UNITY_Q30 - ((ang_sq * poly) >> 30) / 64'd20;
        poly   = UNITY_Q30 - ((ang_sq * poly) >> 30) / 64'd6;
        prod   = (ang * poly) >> 30;
        q15    = (prod + 64'd16384) >> 15;
        if (q15 > 64'd32767)
            q15 = 64'd32767;
        return int'(q15);
    endfunction

    function automatic logic [PHASE_BITS-1:0] voice_step_word(input int v);
        logic [63:0] chz;
        logic [63:0] word;
        if (v < 13)
            chz = 64'(PITCH_CHZ[v]);
        else
            chz = 64'(PITCH_CHZ[v % 12]) << (v / 12);
        word = ((chz << PHASE_BITS) + SAMPLE_RATE_CHZ / 2) / SAMPLE_RATE_CHZ;
        return word[PHASE_BITS-1:0];
    endfunction

    // advances the held voices and mixes one sample tick
    function automatic mix_result_t mix_tick(input logic [KEY_W-1:0] keys);
        mix_result_t                res;
        longint                     acc;
        logic [SINE_ADDR_BITS-1:0]  addr;
        acc = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (v < KEY_W && keys[v])
            begin
                voice_phase[v] = voice_phase[v] + step_word[v];
                addr = voice_phase[v][PHASE_BITS-1 -: SINE_ADDR_BITS];
                acc += (longint'(sine_tab[addr]) * longint'(amp_setting)) / 64'sd32768;
            end
        end
        res.sat = 1'b1;
        if (acc > 32767)
            res.level = SAMPLE_MAX;
        else if (acc < -32768)
            res.level = SAMPLE_MIN;
        else
        begin
            res.level = SAMPLE_W'(acc);
            res.sat = 1'b0;
        end
        return res;
    endfunction

    initial
    begin
        int quadrant;
        int offs;
        int mag;
        for (int a = 0; a < TAB_N; a++)
        begin
            quadrant = a / QTR;
            offs = a % QTR;
            mag = quadrant[0] ? quarter_wave_q15(QTR - offs) : quarter_wave_q15(offs);
            sine_tab[a] = quadrant[1] ? -mag : mag;
        end
        for (int v = 0; v < VOICES; v++)
            step_word[v] = voice_step_word(v);
        mismatches = 0;
        checked = 0;
        clips = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        mix_result_t want;
        if (!rst_n)
        begin
            pending_mix.delete();
            for (int v = 0; v < VOICES; v++)
                voice_phase[v] = '0;
            amp_setting = AMP_RESET;
        end
        else
        begin
            if (psel && penable && pready && !pwrite && paddr == AMP_ADDR &&
                prdata !== PDATA_W'(amp_setting))
            begin
                $display("%0t: amplitude readback expected %0d got %0d",
                         $time, amp_setting, prdata);
                mismatches++;
            end
            if (psel && penable && pwrite && pready && paddr == AMP_ADDR)
                amp_setting = pwdata[AMP_W-1:0];

            if (out_valid && out_ready)
            begin
                if (pending_mix.size() == 0)
                begin
                    $display("%0t: sample %0d clipped %0b with no item pending",
                             $time, sample, clipped);
                    mismatches++;
                end
                else
                begin
                    want = pending_mix.pop_front();
                    checked++;
                    if (clipped === 1'b1)
                        clips++;
                    if (sample !== want.level)
                    begin
                        $display("%0t: sample expected %0d got %0d",
                                 $time, want.level, sample);
                        mismatches++;
                    end
                    if (clipped !== want.sat)
                    begin
                        $display("%0t: clipped expected %0b got %0b",
                                 $time, want.sat, clipped);
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready)
                pending_mix.push_back(mix_tick(key_mask));
        end
        outstanding <= pending_mix.size();
    end

endmodule

/* sim/tb_polyphonic_sine_oscillator_mixer_top.sv */
module tb_polyphonic_sine_oscillator_mixer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psom_pkg::*;

    localparam logic [PADDR_W-1:0] AMP_ADDR   = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);
    localparam logic [KEY_W-1:0]   ALL_KEYS   = '1;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [KEY_W-1:0]           key_mask;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    int mismatches;
    int outstanding;
    int checked;
    int clips;
    int send_idle_pct;
    int recv_stall_pct;
    int keys_sent;
    int quiet_cycles;

    polyphonic_sine_oscillator_mixer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_mask  (key_mask),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .clipped   (clipped),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    sine_mix_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_mask    (key_mask),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .clipped     (clipped),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .clips       (clips)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("polyphonic_sine_oscillator_mixer_top test failed");
                $finish;
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // upper bits of the write are junk, only the low twelve should land
    task automatic set_amplitude(input logic [AMP_W-1:0] amp);
        apb_access(1'b1, AMP_ADDR, {(PDATA_W - AMP_W)'($urandom), amp});
        apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, AMP_ADDR, '0);
    endtask

    task automatic send_keys(input logic [KEY_W-1:0] keys);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_mask <= keys;
        do
            @(posedge clk);
        while (!in_ready);
        keys_sent++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_keys();
        logic [KEY_W-1:0] keys;
        case ($urandom_range(3))
            0: keys = KEY_W'($urandom);
            1: keys = KEY_W'(1) << $urandom_range(KEY_W - 1);
            2: keys = ALL_KEYS & ~(KEY_W'($urandom) & KEY_W'($urandom) & KEY_W'($urandom));
            default: keys = KEY_W'($urandom) & KEY_W'($urandom);
        endcase
        return keys;
    endfunction

    task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                             input logic [AMP_W-1:0] amp);
        wait_idle();
        set_amplitude(amp);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            send_keys(pick_keys());
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [KEY_W-1:0] directed [$];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        key_mask = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        keys_sent = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset amplitude: silence, everything held, each voice alone, alternating keys
        directed = '{KEY_W'(0), ALL_KEYS, ALL_KEYS, ALL_KEYS};
        for (int v = 0; v < KEY_W; v++)
            directed.push_back(KEY_W'(1) << v);
        directed.push_back(KEY_W'('h1555));
        directed.push_back(KEY_W'('h0aaa));
        directed.push_back(ALL_KEYS);
        directed.push_back(KEY_W'(0));
        directed.push_back(ALL_KEYS);
        apb_access(1'b0, AMP_ADDR, '0);
        foreach (directed[i])
            send_keys(directed[i]);
        in_valid <= 1'b0;

        run_phase(110, 0, 0, AMP_W'(4095));
        run_phase(60, 79, 0, AMP_W'(0));
        run_phase(110, 0, 79, AMP_W'($urandom));
        run_phase(100, 29, 29, AMP_W'($urandom));
        run_phase(50, 0, 0, AMP_W'(4095));

        wait_idle();
        $display("sent %0d key items through six amplitude settings incl. 0 and 4095,",
                 keys_sent);
        $display("with idle and stall mixes; %0d samples compared, %0d clipped",
                 checked, clips);
        if (mismatches == 0 && outstanding == 0)
            $display("polyphonic_sine_oscillator_mixer_top test passed");
        else
            $display("polyphonic_sine_oscillator_mixer_top test failed");
        $finish;
    end

endmodule
